### rtl/spq_pkg.sv
// spq_pkg: beat types, command and status codes for the stable sorted priority queue
// no dependencies; used by every module under rtl
package spq_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // match vector is scanned this many bits per cycle
  localparam int unsigned SCAN_W = 8;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] ticket_id;
    logic [7:0]  priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] head_id;
    logic [7:0]  head_priority;
    logic [3:0]  position;
    logic [4:0]  entry_count;
  } out_beat_t;

  // per-cycle control shared by all cells
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // find scanner status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_stat_t;

endpackage

### rtl/stable_sorted_priority_queue.sv
// Stable sorted priority queue: a row of DEPTH cells kept in ascending priority order,
// equal priorities in arrival order. On insert every cell compares the new priority with
// its own and shifts or loads in the same cycle, and pop shifts every cell toward the head.
// Find registers the per-cell id matches and then scans them eight cells per cycle; no new
// beat is taken until the scan ends. A two-deep result buffer lets a new beat in while a
// result still waits. No clearing pass after reset.
// depends on spq_pkg, spq_cell, spq_scan
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ID_BITS       = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spq_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spq_pkg::out_beat_t  out_data
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned NCHUNK = (DEPTH + spq_pkg::SCAN_W - 1) / spq_pkg::SCAN_W;
  localparam int unsigned KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PW     = KW + $clog2(spq_pkg::SCAN_W);

  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic                        in_acc;
  logic                        full;
  logic                        empty;
  spq_pkg::cell_ctl_t          ctl;
  logic [ID_BITS+15:0]         id_ext;
  logic [PRIORITY_BITS+7:0]    pri_ext;
  logic [ID_BITS-1:0]          key_id;
  logic [PRIORITY_BITS-1:0]    key_pri;
  logic [ID_BITS-1:0]          cid  [DEPTH];
  logic [PRIORITY_BITS-1:0]    cpri [DEPTH];
  logic [DEPTH-1:0]            here;
  logic [DEPTH-1:0]            match;
  logic [DEPTH-1:0]            occ;
  spq_pkg::scan_stat_t         scan;
  logic [PW-1:0]               scan_pos;
  logic                        scan_start;
  logic [PW+3:0]               pos_ext;
  logic [CW+4:0]               cnt_ext;
  logic [CW+4:0]               cnt_now_ext;
  logic [ID_BITS+15:0]         hid_ext;
  logic [PRIORITY_BITS+7:0]    hpri_ext;
  logic                        res_vld;
  spq_pkg::out_beat_t          res;
  logic                        out_valid_r;
  logic                        skid_valid_r;
  spq_pkg::out_beat_t          out_r;
  spq_pkg::out_beat_t          skid_r;
  logic                        out_take;

  // input handshake: one item in flight inside, room in the result buffer
  assign in_ready   = !scan.busy && !skid_valid_r;
  assign in_acc     = in_valid && in_ready;
  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);

  // keep the low ID_BITS / PRIORITY_BITS of the request fields
  assign id_ext     = {{ID_BITS{1'b0}}, in_data.ticket_id};
  assign pri_ext    = {{PRIORITY_BITS{1'b0}}, in_data.priority_req};
  assign key_id     = id_ext[ID_BITS-1:0];
  assign key_pri    = pri_ext[PRIORITY_BITS-1:0];

  assign ctl.ins    = in_acc && (in_data.command == spq_pkg::CMD_INSERT) && !full;
  assign ctl.pop    = in_acc && (in_data.command == spq_pkg::CMD_POP) && !empty;
  assign scan_start = in_acc && (in_data.command == spq_pkg::CMD_FIND);

  // chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     l_here;
    logic [ID_BITS-1:0]       l_id;
    logic [PRIORITY_BITS-1:0] l_pri;
    logic [ID_BITS-1:0]       r_id;
    logic [PRIORITY_BITS-1:0] r_pri;

    assign occ[g] = (CW'(g) < count_r);

    if (g == 0) begin : g_head
      assign l_here = 1'b0;
      assign l_id   = key_id;
      assign l_pri  = key_pri;
    end else begin : g_body
      assign l_here = here[g-1];
      assign l_id   = cid[g-1];
      assign l_pri  = cpri[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign r_id  = cid[g];
      assign r_pri = cpri[g];
    end else begin : g_mid
      assign r_id  = cid[g+1];
      assign r_pri = cpri[g+1];
    end

    spq_cell #(
      .ID_BITS      (ID_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ[g]),
      .key_id   (key_id),
      .key_pri  (key_pri),
      .left_here(l_here),
      .left_id  (l_id),
      .left_pri (l_pri),
      .right_id (r_id),
      .right_pri(r_pri),
      .here     (here[g]),
      .match    (match[g]),
      .id_q     (cid[g]),
      .pri_q    (cpri[g])
    );
  end

  // find scanner
  spq_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .hits_in(match),
    .stat   (scan),
    .pos    (scan_pos)
  );

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result fields, masked to their port widths
  assign pos_ext     = {4'b0, scan_pos};
  assign cnt_ext     = {5'b0, count_nxt};
  assign cnt_now_ext = {5'b0, count_r};
  assign hid_ext     = {16'b0, cid[0]};
  assign hpri_ext    = {8'b0, cpri[0]};

  always_comb begin
    res               = '0;
    res_vld           = 1'b0;
    res.entry_count   = cnt_ext[4:0];
    if (scan.done) begin
      res_vld         = 1'b1;
      res.entry_count = cnt_now_ext[4:0];
      if (scan.found) begin
        res.status   = spq_pkg::ST_OK;
        res.position = pos_ext[3:0];
      end else begin
        res.status   = spq_pkg::ST_NOT_FOUND;
      end
    end else if (in_acc) begin
      unique case (in_data.command)
        spq_pkg::CMD_INSERT: begin
          res_vld    = 1'b1;
          res.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end
        spq_pkg::CMD_POP, spq_pkg::CMD_PEEK: begin
          res_vld = 1'b1;
          if (empty) begin
            res.status = spq_pkg::ST_EMPTY;
          end else begin
            res.status        = spq_pkg::ST_OK;
            res.head_id       = hid_ext[15:0];
            res.head_priority = hpri_ext[7:0];
          end
        end
        spq_pkg::CMD_FIND: begin
          res_vld = 1'b0;
        end
        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  // two-deep result buffer: output register plus skid slot
  assign out_take  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_vld) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

`ifndef SYNTHESIS
  // occupancy never passes the number of cells
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  // the skid slot only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot valid with empty output register");

  // no new beat is taken while a find scan runs
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan.busy |-> !in_ready)
    else $error("input accepted during find scan");

  // a result never arrives while the skid slot is occupied
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_vld)
    else $error("result produced with full result buffer");
`endif

endmodule

### rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds an id and a priority
// depends on spq_pkg (cell_ctl_t)
module spq_cell #(
  parameter int unsigned ID_BITS       = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  logic                     occ,
  input  logic [ID_BITS-1:0]       key_id,
  input  logic [PRIORITY_BITS-1:0] key_pri,
  input  logic                     left_here,
  input  logic [ID_BITS-1:0]       left_id,
  input  logic [PRIORITY_BITS-1:0] left_pri,
  input  logic [ID_BITS-1:0]       right_id,
  input  logic [PRIORITY_BITS-1:0] right_pri,
  output logic                     here,
  output logic                     match,
  output logic [ID_BITS-1:0]       id_q,
  output logic [PRIORITY_BITS-1:0] pri_q
);

  logic [ID_BITS-1:0]       id_r;
  logic [PRIORITY_BITS-1:0] pri_r;
  logic [ID_BITS-1:0]       id_nxt;
  logic [PRIORITY_BITS-1:0] pri_nxt;

  // new entry lands at or before this slot: slot is free or holds a later priority
  assign here  = !occ || (pri_r > key_pri);
  assign match = occ && (id_r == key_id);
  assign id_q  = id_r;
  assign pri_q = pri_r;

  // shift toward the tail on insert, toward the head on pop
  always_comb begin
    id_nxt  = id_r;
    pri_nxt = pri_r;
    if (ctl.ins) begin
      if (left_here) begin
        id_nxt  = left_id;
        pri_nxt = left_pri;
      end else if (here) begin
        id_nxt  = key_id;
        pri_nxt = key_pri;
      end
    end else if (ctl.pop) begin
      id_nxt  = right_id;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    pri_r <= pri_nxt;
  end

endmodule

### rtl/spq_scan.sv
// spq_scan: first-match search over the registered match vector, SCAN_W bits per cycle
// depends on spq_pkg (SCAN_W, scan_stat_t)
module spq_scan #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DEPTH-1:0]    hits_in,
  output spq_pkg::scan_stat_t stat,
  output logic [((((DEPTH + spq_pkg::SCAN_W - 1) / spq_pkg::SCAN_W) > 1) ?
                 $clog2((DEPTH + spq_pkg::SCAN_W - 1) / spq_pkg::SCAN_W) : 1) +
                $clog2(spq_pkg::SCAN_W) - 1:0] pos
);

  localparam int unsigned NCHUNK = (DEPTH + spq_pkg::SCAN_W - 1) / spq_pkg::SCAN_W;
  localparam int unsigned KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned BW     = $clog2(spq_pkg::SCAN_W);
  localparam int unsigned PADW   = NCHUNK * spq_pkg::SCAN_W;

  logic [PADW-1:0]           hits_r;
  logic [KW-1:0]             chunk_r;
  logic                      busy_r;
  logic [spq_pkg::SCAN_W-1:0] slice;
  logic [BW-1:0]             bit_idx;
  logic                      any_hit;
  logic                      last_chunk;
  logic [PADW-1:0]           hits_pad;

  assign hits_pad   = PADW'(hits_in);
  assign slice      = hits_r[chunk_r * spq_pkg::SCAN_W +: spq_pkg::SCAN_W];
  assign any_hit    = |slice;
  assign last_chunk = (chunk_r == KW'(NCHUNK - 1));

  // lowest set bit of the current slice
  always_comb begin
    bit_idx = '0;
    for (int i = spq_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (slice[i]) begin
        bit_idx = BW'(i);
      end
    end
  end

  assign stat.busy  = busy_r;
  assign stat.done  = busy_r && (any_hit || last_chunk);
  assign stat.found = any_hit;
  assign pos        = {chunk_r, bit_idx};

  // load on start, walk one slice per cycle until a hit or the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      chunk_r <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      chunk_r <= '0;
    end else if (busy_r) begin
      if (any_hit || last_chunk) begin
        busy_r <= 1'b0;
      end else begin
        chunk_r <= chunk_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hits_r <= hits_pad;
    end
  end

endmodule
